/* hdl/cqd_pkg.sv */
// Shared types, widths, scale tables and helper functions for the coefficient quantiser.
package cqd_pkg;

    localparam int COEFF_W    = 16;
    localparam int QP_W       = 6;
    localparam int SB_W       = 4;
    localparam int L2_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int PER_W      = 4;
    localparam int REM_W      = 3;
    localparam int QSCALE_W   = 15;
    localparam int DTAB_W     = 7;
    localparam int DSCALE_W   = 17;
    localparam int SHAMT_W    = 6;
    localparam int DAMT_W     = 4;
    localparam int QROUND_W   = 40;
    localparam int DROUND_W   = 13;
    localparam int MUL_W      = 18;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 44;
    localparam int SAT_W      = ACC_W + 1;
    localparam int NUM_REM    = 6;
    localparam int MAX_PER    = 10;

    localparam logic [QP_W-1:0] QP_RESET = 6'd0;
    localparam logic [SB_W-1:0] SB_RESET = 4'd8;
    localparam logic [L2_W-1:0] L2_RESET = 3'd2;

    localparam logic [QSCALE_W-1:0] QSCALE [NUM_REM] =
        '{15'd26214, 15'd23302, 15'd20560, 15'd18396, 15'd16384, 15'd14564};
    localparam logic [DTAB_W-1:0] DSCALE [NUM_REM] =
        '{7'd40, 7'd45, 7'd51, 7'd57, 7'd64, 7'd72};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QP = 2'd0,
        CFG_SB = 2'd1,
        CFG_L2 = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [QSCALE_W-1:0] qscale;
        logic [DSCALE_W-1:0] dscale;
        logic [SHAMT_W-1:0]  qsh;
        logic [QROUND_W-1:0] qround;
        logic                dleft;
        logic [DAMT_W-1:0]   damt;
        logic [DROUND_W-1:0] dround;
    } t_cfg;

    typedef struct packed {
        logic                      valid;
        logic                      mode;
        logic signed [COEFF_W-1:0] coeff;
    } t_s1;

    typedef struct packed {
        logic                     valid;
        logic                     mode;
        logic                     neg;
        logic signed [PROD_W-1:0] prod;
    } t_s2;

    typedef struct packed {
        logic                    valid;
        logic                    neg;
        logic                    left;
        logic [SHAMT_W-1:0]      amt;
        logic signed [ACC_W-1:0] acc;
    } t_s3;

    typedef struct packed {
        logic                    valid;
        logic                    neg;
        logic signed [ACC_W-1:0] acc;
    } t_s4;

    function automatic logic [PER_W-1:0] qp_per(input logic [QP_W-1:0] qp);
        logic [PER_W-1:0] per;
        per = '0;
        for (int i = 1; i <= MAX_PER; i++) begin
            if (int'(qp) >= NUM_REM * i) begin
                per = per + PER_W'(1);
            end
        end
        return per;
    endfunction

    function automatic logic [REM_W-1:0] qp_rem(input logic [QP_W-1:0] qp,
                                                input logic [PER_W-1:0] per);
        logic [QP_W-1:0] r;
        r = qp - QP_W'(NUM_REM * int'(per));
        return r[REM_W-1:0];
    endfunction

endpackage

/* hdl/cqd_cfg.sv */
// Configuration registers and the scale, shift and rounding values derived from them.
module cqd_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cqd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cqd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output cqd_pkg::t_cfg                     o_cfg
);

    logic [cqd_pkg::QP_W-1:0]   r_qp;
    logic [cqd_pkg::SB_W-1:0]   r_sb;
    logic [cqd_pkg::L2_W-1:0]   r_l2;
    cqd_pkg::t_cfg              r_cfg;
    cqd_pkg::t_cfg              n_cfg;

    logic [cqd_pkg::PER_W-1:0]  w_per;
    logic [cqd_pkg::REM_W-1:0]  w_rem;
    logic [4:0]                 w_dsum;
    logic [6:0]                 w_qsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qp <= cqd_pkg::QP_RESET;
            r_sb <= cqd_pkg::SB_RESET;
            r_l2 <= cqd_pkg::L2_RESET;
        end else if (i_cfg_we) begin
            unique case (cqd_pkg::t_cfg_idx'(i_cfg_idx))
                cqd_pkg::CFG_QP: r_qp <= i_cfg_wdata[cqd_pkg::QP_W-1:0];
                cqd_pkg::CFG_SB: r_sb <= i_cfg_wdata[cqd_pkg::SB_W-1:0];
                cqd_pkg::CFG_L2: r_l2 <= i_cfg_wdata[cqd_pkg::L2_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_per  = cqd_pkg::qp_per(r_qp);
        w_rem  = cqd_pkg::qp_rem(r_qp, w_per);
        w_dsum = 5'(r_sb) + 5'(r_l2);
        w_qsh  = 7'd29 + 7'(w_per) - 7'(r_sb) - 7'(r_l2);

        n_cfg.qscale = cqd_pkg::QSCALE[w_rem];
        n_cfg.dscale = cqd_pkg::DSCALE_W'(cqd_pkg::DSCALE[w_rem]) << w_per;
        n_cfg.qsh    = w_qsh[cqd_pkg::SHAMT_W-1:0];
        n_cfg.qround = cqd_pkg::QROUND_W'(1) << (n_cfg.qsh - cqd_pkg::SHAMT_W'(1));
        n_cfg.dleft  = (w_dsum <= 5'd9);
        n_cfg.damt   = n_cfg.dleft ? cqd_pkg::DAMT_W'(5'd9 - w_dsum)
                                   : cqd_pkg::DAMT_W'(w_dsum - 5'd9);
        n_cfg.dround = n_cfg.dleft ? '0
                     : cqd_pkg::DROUND_W'(1) << (n_cfg.damt - cqd_pkg::DAMT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/cqd_mult.sv */
// Multiply stage: magnitude by quantiser scale, or signed level by dequantiser scale.
module cqd_mult (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cqd_pkg::t_cfg  i_cfg,
    input  cqd_pkg::t_s1   i_s1,
    output cqd_pkg::t_s2   o_s2
);

    cqd_pkg::t_s2                       r_s2;
    cqd_pkg::t_s2                       n_s2;
    logic signed [cqd_pkg::COEFF_W:0]   w_ext;
    logic [cqd_pkg::COEFF_W:0]          w_mag;
    logic signed [cqd_pkg::MUL_W-1:0]   w_a;
    logic signed [cqd_pkg::MUL_W-1:0]   w_b;

    always_comb begin
        w_ext = {i_s1.coeff[cqd_pkg::COEFF_W-1], i_s1.coeff};
        w_mag = w_ext[cqd_pkg::COEFF_W] ? (-w_ext) : w_ext;
        w_a   = i_s1.mode ? cqd_pkg::MUL_W'(w_ext) : {1'b0, w_mag};
        w_b   = i_s1.mode ? {1'b0, i_cfg.dscale} : {3'b000, i_cfg.qscale};

        n_s2.valid = i_s1.valid;
        n_s2.mode  = i_s1.mode;
        n_s2.neg   = ~i_s1.mode & i_s1.coeff[cqd_pkg::COEFF_W-1];
        n_s2.prod  = w_a * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

/* hdl/cqd_rshift.sv */
// Rounding offset stage followed by the barrel shift stage.
module cqd_rshift (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cqd_pkg::t_cfg  i_cfg,
    input  cqd_pkg::t_s2   i_s2,
    output cqd_pkg::t_s4   o_s4
);

    cqd_pkg::t_s3 r_s3;
    cqd_pkg::t_s3 n_s3;
    cqd_pkg::t_s4 r_s4;
    cqd_pkg::t_s4 n_s4;

    always_comb begin
        n_s3.valid = i_s2.valid;
        n_s3.neg   = i_s2.neg;
        n_s3.left  = i_s2.mode & i_cfg.dleft;
        n_s3.amt   = i_s2.mode ? cqd_pkg::SHAMT_W'(i_cfg.damt) : i_cfg.qsh;
        n_s3.acc   = cqd_pkg::ACC_W'($signed(i_s2.prod))
                   + (i_s2.mode ? cqd_pkg::ACC_W'(i_cfg.dround)
                                : cqd_pkg::ACC_W'(i_cfg.qround));
    end

    always_comb begin
        n_s4.valid = r_s3.valid;
        n_s4.neg   = r_s3.neg;
        n_s4.acc   = r_s3.left ? ($signed(r_s3.acc) <<< r_s3.amt)
                               : ($signed(r_s3.acc) >>> r_s3.amt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_en) begin
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_s4 = r_s4;

endmodule

/* hdl/cqd_sat.sv */
// Output stage: restore sign, saturate to 16 bits and hold the result item.
module cqd_sat (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  cqd_pkg::t_s4                       i_s4,
    output logic                               o_valid,
    output logic signed [cqd_pkg::COEFF_W-1:0] o_coeff,
    output logic                               o_clip
);

    localparam logic signed [cqd_pkg::SAT_W-1:0] SAT_MAX = cqd_pkg::SAT_W'(32767);
    localparam logic signed [cqd_pkg::SAT_W-1:0] SAT_MIN = -cqd_pkg::SAT_W'(32768);

    logic                                r_valid;
    logic signed [cqd_pkg::COEFF_W-1:0]  r_coeff;
    logic signed [cqd_pkg::COEFF_W-1:0]  n_coeff;
    logic                                r_clip;
    logic                                n_clip;
    logic signed [cqd_pkg::SAT_W-1:0]    w_ext;
    logic signed [cqd_pkg::SAT_W-1:0]    w_val;

    always_comb begin
        w_ext = cqd_pkg::SAT_W'($signed(i_s4.acc));
        w_val = i_s4.neg ? (-w_ext) : w_ext;
        priority if (w_val > SAT_MAX) begin
            n_coeff = 16'sh7fff;
            n_clip  = 1'b1;
        end else if (w_val < SAT_MIN) begin
            n_coeff = 16'sh8000;
            n_clip  = 1'b1;
        end else begin
            n_coeff = w_val[cqd_pkg::COEFF_W-1:0];
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_s4.valid;
            r_coeff <= n_coeff;
            r_clip  <= n_clip;
        end
    end

    assign o_valid = r_valid;
    assign o_coeff = r_coeff;
    assign o_clip  = r_clip;

endmodule

/* hdl/coefficient_quant_dequant.sv */
// Top level of the coefficient quantiser and dequantiser pipeline.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_ready    | i_mode, i_coeff_in
//  output  | out       | o_out_valid / i_out_ready  | o_coeff_out, o_clipped
//  config  | in        | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
//  One item per cycle while the output is not stalled; five registers (input, multiply,
//  rounding add, barrel shift, saturate) lie between acceptance and the result item.
//  The 18x18 multiplier and the 44-bit shifter set the stage depth.
//  Reset is synchronous: it clears the stage valid bits and the configuration registers.
//  A stall at the output freezes every stage together; nothing is dropped.
module coefficient_quant_dequant (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cqd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cqd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic signed [cqd_pkg::COEFF_W-1:0] i_coeff_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [cqd_pkg::COEFF_W-1:0] o_coeff_out,
    output logic                               o_clipped
);

    cqd_pkg::t_cfg w_cfg;
    cqd_pkg::t_s1  r_s1;
    cqd_pkg::t_s2  w_s2;
    cqd_pkg::t_s4  w_s4;
    logic          w_en;

    assign w_en       = ~o_out_valid | i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_en) begin
            r_s1.valid <= i_in_valid;
            r_s1.mode  <= i_mode;
            r_s1.coeff <= i_coeff_in;
        end
    end

    cqd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    cqd_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_s1    (r_s1),
        .o_s2    (w_s2)
    );

    cqd_rshift u_rshift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_s2    (w_s2),
        .o_s4    (w_s4)
    );

    cqd_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_s4    (w_s4),
        .o_valid (o_out_valid),
        .o_coeff (o_coeff_out),
        .o_clip  (o_clipped)
    );

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_coeff_out == 16'sh7fff || o_coeff_out == 16'sh8000))
        else $error("clipped item not at a saturation limit");

    a_valid_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && w_en) |=> w_s2.valid)
        else $error("item lost between input and multiply stage");

    a_neg_quant_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s4.valid && w_s4.neg && w_en) |=> ($signed(o_coeff_out) <= 16'sd0))
        else $error("negative coefficient quantised to a positive level");

endmodule

/* dv/coefficient_quant_dequant_tb.sv */
// Self-checking testbench for the coefficient quantiser and dequantiser, driven with random items.
module coefficient_quant_dequant_tb;

    localparam int                            WATCHDOG_LIMIT = 2000;
    localparam int                            HOLD_OFF_CYCLES = 300;
    localparam int                            MAX_REPORTS = 40;
    localparam logic [cqd_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam logic                          MODE_QUANT = 1'b0;
    localparam logic                          MODE_DEQUANT = 1'b1;
    localparam longint QSTEP [6] = '{26214, 23302, 20560, 18396, 16384, 14564};
    localparam longint DSTEP [6] = '{40, 45, 51, 57, 64, 72};

    typedef struct {
        logic                               mode;
        logic signed [cqd_pkg::COEFF_W-1:0] coeff;
    } t_coeff_item;

    typedef struct {
        logic signed [cqd_pkg::COEFF_W-1:0] coeff;
        logic                               clip;
    } t_coeff_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [cqd_pkg::CFG_IDX_W-1:0]      i_cfg_idx = cqd_pkg::CFG_QP;
    logic [cqd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_mode = MODE_QUANT;
    logic signed [cqd_pkg::COEFF_W-1:0] i_coeff_in = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic signed [cqd_pkg::COEFF_W-1:0] o_coeff_out;
    logic                               o_clipped;

    t_coeff_item                        pending_items [$];
    t_coeff_result                      coeff_expected [$];
    logic [cqd_pkg::QP_W-1:0]           qp_cur = cqd_pkg::QP_RESET;
    logic [cqd_pkg::SB_W-1:0]           sb_cur = cqd_pkg::SB_RESET;
    logic [cqd_pkg::L2_W-1:0]           l2_cur = cqd_pkg::L2_RESET;
    int                                 n_pushed = 0;
    int                                 n_results = 0;
    int                                 errors = 0;
    int                                 idle_cycles = 0;
    bit                                 calm = 1'b0;
    bit                                 quiet = 1'b0;
    bit                                 hold_req = 1'b0;

    coefficient_quant_dequant uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_coeff_in  (i_coeff_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_coeff_out (o_coeff_out),
        .o_clipped   (o_clipped)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_coeff_result quant_predict(
            input logic mode, input logic signed [cqd_pkg::COEFF_W-1:0] c);
        t_coeff_result r;
        longint        per;
        longint        rm;
        longint        sh;
        longint        mag;
        longint        acc;
        longint        v;
        per = longint'(int'(qp_cur) / 6);
        rm  = longint'(int'(qp_cur) % 6);
        if (mode == MODE_QUANT) begin
            sh  = 29 + per - longint'(int'(sb_cur)) - longint'(int'(l2_cur));
            mag = (c < 0) ? -longint'(c) : longint'(c);
            acc = mag * QSTEP[rm] + (longint'(1) << (sh - 1));
            acc = acc >>> sh;
            v   = (c < 0) ? -acc : acc;
        end else begin
            sh  = longint'(int'(sb_cur)) + longint'(int'(l2_cur)) - 9;
            acc = longint'(c) * (DSTEP[rm] << per);
            if (sh <= 0) begin
                v = acc << (-sh);
            end else begin
                v = (acc + (longint'(1) << (sh - 1))) >>> sh;
            end
        end
        r.clip = 1'b1;
        if (v > 32767) begin
            r.coeff = 16'sh7fff;
        end else if (v < -32768) begin
            r.coeff = 16'sh8000;
        end else begin
            r.coeff = v[cqd_pkg::COEFF_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [cqd_pkg::COEFF_W-1:0] random_coeff();
        logic signed [cqd_pkg::COEFF_W-1:0] c;
        int                                 k;
        k = $urandom_range(0, 14);
        case ($urandom_range(0, 5))
            0: c = cqd_pkg::COEFF_W'($urandom_range(0, 128)) - 16'sd64;
            1: c = cqd_pkg::COEFF_W'($urandom_range(0, 4096)) - 16'sd2048;
            2: begin
                case ($urandom_range(0, 4))
                    0: c = 16'sh7fff;
                    1: c = 16'sh8000;
                    2: c = 16'sd0;
                    3: c = 16'sd1;
                    default: c = -16'sd1;
                endcase
            end
            3: begin
                c = cqd_pkg::COEFF_W'(1 << k) + cqd_pkg::COEFF_W'($urandom_range(0, 2))
                  - 16'sd1;
                if ($urandom_range(0, 1) == 1) begin
                    c = -c;
                end
            end
            default: c = cqd_pkg::COEFF_W'($urandom);
        endcase
        return c;
    endfunction

    task automatic push_item(input logic mode, input logic signed [cqd_pkg::COEFF_W-1:0] c);
        t_coeff_item it;
        it.mode  = mode;
        it.coeff = c;
        pending_items.push_back(it);
        n_pushed++;
    endtask

    task automatic write_reg(input logic [cqd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cqd_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == cqd_pkg::CFG_QP) begin
            qp_cur = val;
        end else if (idx == cqd_pkg::CFG_SB) begin
            sb_cur = val[cqd_pkg::SB_W-1:0];
        end else if (idx == cqd_pkg::CFG_L2) begin
            l2_cur = val[cqd_pkg::L2_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input int qp, input int sb, input int l2);
        write_reg(cqd_pkg::CFG_QP, cqd_pkg::CFG_DATA_W'(qp));
        write_reg(cqd_pkg::CFG_SB, {2'($urandom_range(0, 3)), 4'(sb)});
        write_reg(cqd_pkg::CFG_L2, {3'($urandom_range(0, 7)), 3'(l2)});
    endtask

    task automatic settle();
        while (n_results < n_pushed) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n);
        calm = ($urandom_range(0, 3) == 0);
        push_item(MODE_QUANT, 16'sh7fff);
        push_item(MODE_DEQUANT, 16'sh8000);
        for (int i = 0; i < n; i++) begin
            push_item(logic'($urandom_range(0, 1)), random_coeff());
        end
        settle();
    endtask

    // driver
    always @(posedge i_clk) begin
        t_coeff_item it;
        int          gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                coeff_expected.push_back(quant_predict(i_mode, i_coeff_in));
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the offered item
            end else if (gap > 0) begin
                gap--;
                i_in_valid <= 1'b0;
            end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 13) - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_mode     <= it.mode;
                i_coeff_in <= it.coeff;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_coeff_result want;
        int            stall;
        int            hold_cnt;
        bit            hold_taken;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall = 0;
            hold_cnt = 0;
            hold_taken = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (coeff_expected.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected item, expected none, actual %0d clipped %0b",
                                 $time, o_coeff_out, o_clipped);
                    end
                end else begin
                    want = coeff_expected.pop_front();
                    if (o_coeff_out !== want.coeff) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: coeff_out mismatch, expected %0d, actual %0d",
                                     $time, want.coeff, o_coeff_out);
                        end
                    end
                    if (o_clipped !== want.clip) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: clipped mismatch, expected %0b, actual %0b",
                                     $time, want.clip, o_clipped);
                        end
                    end
                end
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_cnt = HOLD_OFF_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 13) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            n_results >= n_pushed) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int qp_tab [8];
        int sb_tab [8];
        int l2_tab [8];
        int qp;
        int sb;
        int l2;
        qp_tab = '{0, 51, 51, 0, 63, 0, 63, 7};
        sb_tab = '{8, 12, 8, 12, 15, 0, 0, 7};
        l2_tab = '{2, 5, 2, 5, 7, 0, 0, 2};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (qp_tab[i]) begin
            if (i == 0) begin
                // reset settings first, before any register write
                push_item(MODE_QUANT, 16'sd0);
                push_item(MODE_DEQUANT, 16'sd0);
                push_item(MODE_QUANT, 16'sd1);
                push_item(MODE_DEQUANT, 16'sd1);
                push_item(MODE_QUANT, -16'sd1);
                push_item(MODE_DEQUANT, -16'sd1);
                push_item(MODE_QUANT, 16'sh8000);
                push_item(MODE_DEQUANT, 16'sh7fff);
                push_item(MODE_QUANT, 16'sd12345);
                push_item(MODE_DEQUANT, -16'sd12345);
                settle();
                write_reg(CFG_NONE, cqd_pkg::CFG_DATA_W'($urandom));
            end
            configure(qp_tab[i], sb_tab[i], l2_tab[i]);
            if (i == 2) begin
                hold_req = 1'b1;
            end
            run_phase(60);
        end

        for (int p = 0; p < 15; p++) begin
            qp = ($urandom_range(0, 5) == 0) ? $urandom_range(52, 63) : $urandom_range(0, 51);
            sb = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(8, 12);
            l2 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 5);
            configure(qp, sb, l2);
            run_phase(60);
        end

        quiet = 1'b1;
        configure($urandom_range(0, 51), $urandom_range(8, 12), $urandom_range(2, 5));
        run_phase(60);

        if (coeff_expected.size() != 0) begin
            errors++;
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
